// ----- hdl/fwtc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwtc_pkg: shared types and constants of the Fenwick range-count block
// Holds the request beat type, operation codes and the walker state codes.
// ----------------------------------------------------------------------------
package fwtc_pkg;

  // Width of positions, of the register and of the reported count.
  localparam int POS_W = 11;

  // Largest count that the result field can carry.
  localparam logic [POS_W-1:0] COUNT_SAT = 11'h7FF;

  // Operation codes carried on the input sideband.
  localparam logic FUNC_TOGGLE = 1'b0;
  localparam logic FUNC_COUNT  = 1'b1;

  // One request beat as handed from the top level to the tree walker.
  typedef struct packed {
    logic             func;
    logic [POS_W-1:0] first_position;
    logic [POS_W-1:0] last_position;
  } fwtc_req_t;

  // Walker states, one-hot.
  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_UPD   = 5'b00100,
    ST_SUM   = 5'b01000,
    ST_DONE  = 5'b10000
  } fwtc_state_t;

endpackage

// ----- hdl/fwtc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwtc_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module fwtc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/fwtc_walk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwtc_walk: Fenwick tree walker
// Keeps the presence bits and tree counts in one RAM (entry i at address
// i - 1, presence bit on top) and walks update and prefix paths over it,
// one entry per cycle.
// ----------------------------------------------------------------------------
module fwtc_walk #(
  parameter int MAX_POSITIONS = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [fwtc_pkg::POS_W-1:0] positions_in_use,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  fwtc_pkg::fwtc_req_t        req,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic [fwtc_pkg::POS_W-1:0] res_count
);

  localparam int PW = $clog2(MAX_POSITIONS + 1);
  localparam int AW = $clog2(MAX_POSITIONS);
  localparam int DW = PW + 1;
  localparam int XW = (PW > fwtc_pkg::POS_W) ? PW : fwtc_pkg::POS_W;
  localparam logic [PW:0]   MAX_UP  = (PW + 1)'(MAX_POSITIONS);
  localparam logic [AW-1:0] CLR_END = AW'(MAX_POSITIONS - 1);
  localparam logic [PW-1:0] ONE_P   = PW'(1);

  fwtc_pkg::fwtc_state_t state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [PW-1:0] idx_r, idx_nxt;
  logic [PW-1:0] lo_r, lo_nxt;
  logic [PW-1:0] acc_r, acc_nxt;
  logic          sub_r, sub_nxt;
  logic          first_step_r, first_step_nxt;
  logic          inc_r, inc_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;
  logic [PW-1:0] rd_pos;

  logic [PW-1:0]                ent_cnt;
  logic                         ent_pres;
  logic [PW-1:0]                lsb;
  logic [PW:0]                  up_next;
  logic [PW-1:0]                dn_next;
  logic [PW-1:0]                clr_pos;
  logic                         inc_now;
  logic                         pres_now;
  logic [fwtc_pkg::POS_W-1:0]   cnt_first;
  logic [fwtc_pkg::POS_W-1:0]   cnt_last;
  logic                         req_fire;
  logic                         tgl_ok;

  assign ent_cnt   = ram_rdata[PW-1:0];
  assign ent_pres  = ram_rdata[PW];
  assign lsb       = idx_r & (~idx_r + ONE_P);
  assign up_next   = {1'b0, idx_r} + {1'b0, lsb};
  assign dn_next   = idx_r - lsb;
  assign clr_pos   = PW'(clr_r) + ONE_P;
  assign req_fire  = req_valid && req_ready;
  assign inc_now   = first_step_r ? ~ent_pres : inc_r;
  assign pres_now  = first_step_r ? ~ent_pres : ent_pres;

  // Range ends: first position zero reads as one, last clamped to the
  // number of positions in use.
  assign cnt_first = (req.first_position == '0) ? fwtc_pkg::POS_W'(1) : req.first_position;
  assign cnt_last  = (req.last_position > positions_in_use) ? positions_in_use
                                                            : req.last_position;
  assign tgl_ok    = (req.first_position != '0) && (req.first_position <= positions_in_use);

  // Handshake towards the top level.
  assign req_ready = (state_r == fwtc_pkg::ST_IDLE);
  assign res_valid = (state_r == fwtc_pkg::ST_DONE);
  assign res_count = (XW'(acc_r) > XW'(fwtc_pkg::COUNT_SAT)) ? fwtc_pkg::COUNT_SAT
                                                             : fwtc_pkg::POS_W'(acc_r);

  // Sequencer: clearing pass, update walk, two prefix walks.
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    idx_nxt        = idx_r;
    lo_nxt         = lo_r;
    acc_nxt        = acc_r;
    sub_nxt        = sub_r;
    first_step_nxt = first_step_r;
    inc_nxt        = inc_r;
    ram_we         = 1'b0;
    ram_waddr      = AW'(idx_r - ONE_P);
    ram_wdata      = {pres_now, inc_now ? ent_cnt + ONE_P : ent_cnt - ONE_P};
    ram_re         = 1'b0;
    rd_pos         = idx_r;
    unique case (state_r)
      fwtc_pkg::ST_CLEAR: begin
        // Entry i starts with its bit set and a count of lowbit(i).
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = {1'b1, clr_pos & (~clr_pos + ONE_P)};
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == CLR_END) begin
          state_nxt = fwtc_pkg::ST_IDLE;
        end
      end
      fwtc_pkg::ST_IDLE: begin
        if (req_fire) begin
          if (req.func == fwtc_pkg::FUNC_TOGGLE) begin
            if (tgl_ok) begin
              idx_nxt        = PW'(req.first_position);
              rd_pos         = PW'(req.first_position);
              ram_re         = 1'b1;
              first_step_nxt = 1'b1;
              state_nxt      = fwtc_pkg::ST_UPD;
            end
          end else begin
            acc_nxt = '0;
            if (cnt_first > cnt_last) begin
              state_nxt = fwtc_pkg::ST_DONE;
            end else begin
              idx_nxt   = PW'(cnt_last);
              lo_nxt    = PW'(cnt_first - fwtc_pkg::POS_W'(1));
              rd_pos    = PW'(cnt_last);
              ram_re    = 1'b1;
              sub_nxt   = 1'b0;
              state_nxt = fwtc_pkg::ST_SUM;
            end
          end
        end
      end
      fwtc_pkg::ST_UPD: begin
        // Write back this entry and fetch the next one up the path.
        ram_we         = 1'b1;
        inc_nxt        = inc_now;
        first_step_nxt = 1'b0;
        if (up_next > MAX_UP) begin
          state_nxt = fwtc_pkg::ST_IDLE;
        end else begin
          idx_nxt = up_next[PW-1:0];
          rd_pos  = up_next[PW-1:0];
          ram_re  = 1'b1;
        end
      end
      fwtc_pkg::ST_SUM: begin
        // Add entries of prefix(last), then subtract those of prefix(first-1).
        acc_nxt = sub_r ? acc_r - ent_cnt : acc_r + ent_cnt;
        if (dn_next != '0) begin
          idx_nxt = dn_next;
          rd_pos  = dn_next;
          ram_re  = 1'b1;
        end else if (!sub_r && (lo_r != '0)) begin
          sub_nxt = 1'b1;
          idx_nxt = lo_r;
          rd_pos  = lo_r;
          ram_re  = 1'b1;
        end else begin
          state_nxt = fwtc_pkg::ST_DONE;
        end
      end
      fwtc_pkg::ST_DONE: begin
        if (res_ready) begin
          state_nxt = fwtc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fwtc_pkg::ST_CLEAR;
      end
    endcase
  end

  assign ram_raddr = AW'(rd_pos - ONE_P);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fwtc_pkg::ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // Walk registers.
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    lo_r         <= lo_nxt;
    acc_r        <= acc_nxt;
    sub_r        <= sub_nxt;
    first_step_r <= first_step_nxt;
    inc_r        <= inc_nxt;
  end

  fwtc_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_POSITIONS)
  ) u_tree_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A prefix walk never writes the tree.
  a_sum_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fwtc_pkg::ST_SUM) |-> !ram_we)
    else $error("tree written during a prefix walk");

  // The clearing pass writes one entry every cycle.
  a_clear_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fwtc_pkg::ST_CLEAR) |-> ram_we)
    else $error("clearing pass skipped a cycle");

  // An update path climbs strictly.
  a_upd_climbs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fwtc_pkg::ST_UPD) && ($past(state_r) == fwtc_pkg::ST_UPD)
    |-> (idx_r > $past(idx_r)))
    else $error("update path did not climb");

  // A taken result returns the walker to idle.
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fwtc_pkg::ST_DONE) && res_ready |=> (state_r == fwtc_pkg::ST_IDLE))
    else $error("result handed over but walker not idle");

endmodule

// ----- hdl/fenwick_toggle_range_count_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fenwick_toggle_range_count_core: toggle and range-count over a Fenwick tree
// Presence bits and tree counts held in one RAM, walked one entry per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on in_* carry an operation in in_tuser: a toggle of one
//   position (no result) or a count of set bits between two positions
//   (one result beat on out_*). cfg_* writes positions_in_use; it must
//   only be written while the block is idle, which the block itself does
//   not enforce, and cfg_* is always ready. One item is worked at a time.
//   A toggle is accepted and then walks the tree entries on its update
//   path, up to log2(MAX_POSITIONS) + 1 of them. A count is accepted,
//   walks the entries on the two prefix paths (up to 2 * log2(MAX_POSITIONS))
//   and then hands over the result. The single RAM read port limits the
//   walks to one entry per cycle.
//   After reset a clearing pass writes all MAX_POSITIONS entries, setting
//   every bit and loading each tree entry; in_tready stays low meanwhile.
//   The result sits in an output register, so the next item is accepted
//   while a result waits; a finished count holds the walker until the
//   output register is free.
// ----------------------------------------------------------------------------
module fenwick_toggle_range_count_core #(
  parameter int MAX_POSITIONS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data,      // positions_in_use
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // [10:0] first_position, [21:11] last_position
  input  logic        in_tuser,      // [0] func
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata      // [10:0] set_count
);

  localparam int PW = $clog2(MAX_POSITIONS + 1);
  localparam int XW = (PW > fwtc_pkg::POS_W) ? PW : fwtc_pkg::POS_W;
  localparam logic [XW-1:0] MAX_X = XW'(MAX_POSITIONS);
  localparam logic [fwtc_pkg::POS_W-1:0] N_RST =
    fwtc_pkg::POS_W'((MAX_POSITIONS < 1024) ? MAX_POSITIONS : 1024);

  logic [fwtc_pkg::POS_W-1:0] n_r, n_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [fwtc_pkg::POS_W-1:0] out_count_r;
  fwtc_pkg::fwtc_req_t        req;
  logic                       res_valid, res_ready;
  logic [fwtc_pkg::POS_W-1:0] res_count;

  // Configuration register: zero reads as one, large values saturate.
  assign cfg_ready = 1'b1;
  always_comb begin
    n_nxt = n_r;
    if (cfg_valid && cfg_ready) begin
      priority if (cfg_data == '0) begin
        n_nxt = fwtc_pkg::POS_W'(1);
      end else if (XW'(cfg_data) > MAX_X) begin
        n_nxt = fwtc_pkg::POS_W'(MAX_POSITIONS);
      end else begin
        n_nxt = cfg_data;
      end
    end
  end

  // Request beat unpacking.
  assign req.func           = in_tuser;
  assign req.first_position = in_tdata[10:0];
  assign req.last_position  = in_tdata[21:11];

  // Output register: free when empty or being drained this cycle.
  assign res_ready     = !out_valid_r || out_tready;
  assign out_valid_nxt = (res_valid && res_ready) || (out_valid_r && !out_tready);
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = {5'b0, out_count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= N_RST;
      out_valid_r <= 1'b0;
    end else begin
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_count_r <= res_count;
    end
  end

  fwtc_walk #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_walk (
    .clk              (clk),
    .rst_n            (rst_n),
    .positions_in_use (n_r),
    .req_valid        (in_tvalid),
    .req_ready        (in_tready),
    .req              (req),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res_count        (res_count)
  );

endmodule

// ----- tb/fenwick_toggle_range_count_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fenwick_toggle_range_count_core_tb: self-checking bench for the range counter
// Drives toggles and range counts under bursty input and a stalling receiver.
// A software Fenwick tree predicts every count, and the bench compares each
// result beat with it. Positions_in_use is stepped through its extremes.
// ----------------------------------------------------------------------------
module fenwick_toggle_range_count_core_tb;

  localparam int TREE_SIZE      = 1024;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PER_SET = 120;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_ALTERNATE
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;      // [10:0] first_position, [21:11] last_position
  logic        in_tuser = 1'b0;    // [0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [10:0] set_count

  fenwick_toggle_range_count_core #(
    .MAX_POSITIONS(TREE_SIZE)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Clock generation.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Requests waiting to be offered, and counts still owed by the block.
  fwtc_pkg::fwtc_req_t pending_q[$];
  logic [10:0]         count_q[$];

  int errors          = 0;
  int toggles_applied = 0;
  int toggles_ignored = 0;
  int counts_checked  = 0;
  int settings_used   = 1;
  int hold_asked      = 0;

  // Shadow copy of the presence row, the tree and the register.
  logic        presence [1:TREE_SIZE];
  logic [10:0] tree_cnt [1:TREE_SIZE];
  int unsigned n_used;

  function automatic int unsigned low_bit(int unsigned v);
    return v & (~v + 1);
  endfunction

  function automatic void clear_shadow();
    for (int i = 1; i <= TREE_SIZE; i++) begin
      presence[i] = 1'b1;
      tree_cnt[i] = 11'(low_bit(i));
    end
    n_used = TREE_SIZE;
  endfunction

  function automatic void set_positions(logic [10:0] v);
    if (v == 0)
      n_used = 1;
    else if (v > TREE_SIZE)
      n_used = TREE_SIZE;
    else
      n_used = 32'(v);
  endfunction

  function automatic int unsigned tree_prefix(int unsigned upto);
    int unsigned total;
    int unsigned i;
    total = 0;
    i = (upto > TREE_SIZE) ? TREE_SIZE : upto;
    while (i != 0) begin
      total += 32'(tree_cnt[i]);
      i -= low_bit(i);
    end
    return total;
  endfunction

  // Flip one presence bit and walk the update path to the top of the tree.
  function automatic bit toggle_position(logic [10:0] pos);
    int unsigned i;
    if (pos == 0 || pos > n_used)
      return 1'b0;
    presence[pos] = ~presence[pos];
    for (i = 32'(pos); i <= TREE_SIZE; i += low_bit(i))
      tree_cnt[i] = presence[pos] ? tree_cnt[i] + 11'd1 : tree_cnt[i] - 11'd1;
    return 1'b1;
  endfunction

  function automatic logic [10:0] range_count(logic [10:0] first, logic [10:0] last);
    int unsigned lo;
    int unsigned hi;
    int unsigned cnt;
    lo = (first == 0) ? 1 : 32'(first);
    hi = (last > n_used) ? n_used : 32'(last);
    cnt = 0;
    if (lo <= hi)
      cnt = tree_prefix(hi) - tree_prefix(lo - 1);
    if (cnt > fwtc_pkg::COUNT_SAT)
      cnt = 32'(fwtc_pkg::COUNT_SAT);
    return cnt[10:0];
  endfunction

  function automatic void push_item(logic func, logic [10:0] first, logic [10:0] last);
    fwtc_pkg::fwtc_req_t it;
    it.func           = func;
    it.first_position = first;
    it.last_position  = last;
    pending_q.push_back(it);
  endfunction

  // Mostly well-formed toggles and ranges inside n, with some wide noise.
  function automatic void push_random(int unsigned n);
    int unsigned sel;
    logic [10:0] a;
    logic [10:0] b;
    logic [10:0] wa;
    logic [10:0] wb;
    sel = $urandom_range(0, 99);
    a  = 11'($urandom_range(1, n));
    b  = 11'($urandom_range(1, n));
    wa = 11'($urandom_range(0, 2047));
    wb = 11'($urandom_range(0, 2047));
    if (sel < 45)
      push_item(fwtc_pkg::FUNC_TOGGLE, a, wb);
    else if (sel < 75)
      push_item(fwtc_pkg::FUNC_COUNT, (a < b) ? a : b, (a < b) ? b : a);
    else if (sel < 80)
      push_item(fwtc_pkg::FUNC_COUNT, (a < b) ? b : a, (a < b) ? a : b);
    else if (sel < 90)
      push_item(fwtc_pkg::FUNC_COUNT, wa, wb);
    else
      push_item(fwtc_pkg::FUNC_TOGGLE, wa, wb);
  endfunction

  // Input driver: bursts of beats separated by random gaps.
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    fwtc_pkg::fwtc_req_t it;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (in_tuser == fwtc_pkg::FUNC_TOGGLE) begin
          if (toggle_position(in_tdata[10:0]))
            toggles_applied++;
          else
            toggles_ignored++;
        end else begin
          count_q.push_back(range_count(in_tdata[10:0], in_tdata[21:11]));
        end
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left  <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          it = pending_q.pop_front();
          in_tdata  <= {2'b00, it.last_position, it.first_position};
          in_tuser  <= it.func;
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            if ($urandom_range(0, 7) == 0) begin
              burst_left <= $urandom_range(40, 80);
              gap_left   <= 0;
            end else begin
              burst_left <= $urandom_range(1, 12);
              gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
            end
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall pattern.
  rx_mode_t rx_mode   = RX_ALWAYS;
  int       mode_left = 0;
  int       hold_seen = 0;
  int       hold_left = 0;
  logic     rx_phase  = 1'b0;

  always @(posedge clk) begin
    logic [10:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (count_q.size() == 0) begin
          $display("%0t: result beat with no count pending, actual %0d", $time, out_tdata);
          errors++;
        end else begin
          want = count_q.pop_front();
          counts_checked++;
          if (out_tdata !== {5'b00000, want}) begin
            $display("%0t: set_count mismatch, expected %0d actual %0d",
                     $time, want, out_tdata);
            errors++;
          end
        end
      end
      rx_phase <= ~rx_phase;
      if (hold_seen != hold_asked) begin
        hold_seen  <= hold_asked;
        hold_left  <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   <= rx_mode_t'($urandom_range(0, 3));
          mode_left <= $urandom_range(20, 200);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (rx_mode)
          RX_ALWAYS:    out_tready <= 1'b1;
          RX_COIN:      out_tready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE:    out_tready <= ($urandom_range(0, 3) == 0);
          RX_ALTERNATE: out_tready <= rx_phase;
          default:      out_tready <= 1'b1;
        endcase
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Wait until the block has drained, then let any toggle walk finish.
  // The queues and the valid are looked at on the falling edge, once the
  // driver and monitor have settled for the cycle.
  task automatic wait_drained();
    while (pending_q.size() != 0 || in_tvalid || count_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_setting(logic [10:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    set_positions(v);
    settings_used++;
  endtask

  // Stimulus sequence.
  initial begin
    logic [10:0] settings [12];
    settings  = '{11'd1, 11'd0, 11'd1024, 11'd7, 11'd2047, 11'd300,
                  11'd16, 11'd1500, 11'd1023, 11'd2, 11'd64, 11'd1024};
    clear_shadow();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items with the reset setting of 1024 positions.
    push_item(fwtc_pkg::FUNC_COUNT,  11'd1,    11'd1024);
    push_item(fwtc_pkg::FUNC_COUNT,  11'd0,    11'd2047);  // first zero, last clamped
    push_item(fwtc_pkg::FUNC_COUNT,  11'd1024, 11'd1024);
    push_item(fwtc_pkg::FUNC_COUNT,  11'd1,    11'd1);
    push_item(fwtc_pkg::FUNC_COUNT,  11'd5,    11'd3);     // empty range
    push_item(fwtc_pkg::FUNC_TOGGLE, 11'd0,    11'd0);     // ignored, position zero
    push_item(fwtc_pkg::FUNC_TOGGLE, 11'd1025, 11'd2047);  // ignored, above n
    push_item(fwtc_pkg::FUNC_TOGGLE, 11'd2047, 11'd0);
    push_item(fwtc_pkg::FUNC_TOGGLE, 11'd1,    11'd2047);
    push_item(fwtc_pkg::FUNC_TOGGLE, 11'd1024, 11'd0);
    push_item(fwtc_pkg::FUNC_TOGGLE, 11'd512,  11'd0);
    push_item(fwtc_pkg::FUNC_COUNT,  11'd1,    11'd1024);
    push_item(fwtc_pkg::FUNC_COUNT,  11'd512,  11'd512);
    push_item(fwtc_pkg::FUNC_TOGGLE, 11'd1,    11'd0);
    push_item(fwtc_pkg::FUNC_COUNT,  11'd1,    11'd2);
    push_item(fwtc_pkg::FUNC_COUNT,  11'd2047, 11'd2047);
    push_item(fwtc_pkg::FUNC_COUNT,  11'd0,    11'd0);
    push_item(fwtc_pkg::FUNC_TOGGLE, 11'd1024, 11'd1024);
    push_item(fwtc_pkg::FUNC_COUNT,  11'd1000, 11'd2000);
    push_item(fwtc_pkg::FUNC_COUNT,  11'd1023, 11'd1024);

    // Random phases, each under a new register setting.
    foreach (settings[p]) begin
      wait_drained();
      write_setting(settings[p]);
      for (int k = 0; k < RANDOM_PER_SET; k++)
        push_random(n_used);
      if (p == 2) begin
        @(posedge clk);
        hold_asked <= hold_asked + 1;
      end
    end

    wait_drained();
    if (count_q.size() != 0) begin
      $display("%0t: %0d counts never returned", $time, count_q.size());
      errors++;
    end
    $display("Covered %0d applied and %0d ignored toggles, %0d checked counts,",
             toggles_applied, toggles_ignored, counts_checked);
    $display("over %0d settings of positions_in_use, with %0d errors.",
             settings_used, errors);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
